FILE: rtl/core/esf_pkg.sv
// Shared types and line codes for the escape-stuffed frame encoder.
`default_nettype none
package esf_pkg;

  localparam logic [7:0] CODE_ESC = 8'h1B;
  localparam logic [7:0] CODE_STX = 8'h02;
  localparam logic [7:0] CODE_ETX = 8'h03;

  // Slot positions in the per-request byte plan, in line order.
  localparam int SLOT_HDR_ESC = 0;
  localparam int SLOT_HDR_STX = 1;
  localparam int SLOT_DATA    = 2;
  localparam int SLOT_DUP_ESC = 3;
  localparam int SLOT_TRL_ESC = 4;
  localparam int SLOT_TRL_ETX = 5;
  localparam int SLOT_CSUM    = 6;
  localparam int NUM_SLOTS    = 7;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [NUM_SLOTS-1:0] esf_slots_t;

  typedef struct packed {
    esf_slots_t  slots;
    logic [7:0]  data;
    logic [7:0]  csum;
  } esf_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/esf_front.sv
// Front end: accepts payload bytes, tracks frame state and plans output slots.
`default_nettype none
module esf_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [7:0]      in_data_byte,
  input  wire logic            in_last_byte,
  input  wire logic            q_full,
  output logic                 q_push,
  output esf_pkg::esf_cmd_t    q_cmd
);
  import esf_pkg::*;

  logic       inside_frame_r, inside_frame_nxt;
  logic [7:0] running_xor_r, running_xor_nxt;
  logic [7:0] xor_sum;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Header only on the first byte of a frame, so the old sum is dropped there.
  assign xor_sum = (inside_frame_r ? running_xor_r : 8'h00) ^ in_data_byte;

  always_comb begin
    q_cmd.slots               = '0;
    q_cmd.slots[SLOT_HDR_ESC] = !inside_frame_r;
    q_cmd.slots[SLOT_HDR_STX] = !inside_frame_r;
    q_cmd.slots[SLOT_DATA]    = 1'b1;
    q_cmd.slots[SLOT_DUP_ESC] = (in_data_byte == CODE_ESC);
    q_cmd.slots[SLOT_TRL_ESC] = in_last_byte;
    q_cmd.slots[SLOT_TRL_ETX] = in_last_byte;
    q_cmd.slots[SLOT_CSUM]    = in_last_byte;
    q_cmd.data                = in_data_byte;
    q_cmd.csum                = xor_sum ^ CODE_ETX;
  end

  always_comb begin
    inside_frame_nxt = inside_frame_r;
    running_xor_nxt  = running_xor_r;
    if (q_push) begin
      inside_frame_nxt = !in_last_byte;
      running_xor_nxt  = in_last_byte ? 8'h00 : xor_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_frame_r <= 1'b0;
      running_xor_r  <= 8'h00;
    end else begin
      inside_frame_r <= inside_frame_nxt;
      running_xor_r  <= running_xor_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/esf_queue.sv
// Small request queue between the front end and the byte sequencer.
`default_nettype none
module esf_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire esf_pkg::esf_cmd_t  push_cmd,
  output logic                    full,
  input  wire logic               pop,
  output esf_pkg::esf_cmd_t       pop_cmd,
  output logic                    empty
);
  import esf_pkg::*;

  esf_cmd_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/esf_back.sv
// Back end: walks each request's slot plan and drives one line byte per cycle while out_stall is low.
`default_nettype none
module esf_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire esf_pkg::esf_cmd_t  q_cmd,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_line_byte,
  output logic                    out_run_last,
  output logic                    out_frame_end
);
  import esf_pkg::*;

  logic       busy_r, busy_nxt;
  esf_slots_t slots_r, slots_nxt;
  logic [7:0] data_r, csum_r;
  logic       out_valid_r;
  logic [7:0] line_byte_r;
  logic       run_last_r, frame_end_r;

  esf_slots_t cur_bit, rest;
  logic       out_ready, emit, need_load;
  logic [7:0] cur_byte;

  assign out_ready = !out_valid_r || !out_stall;
  // Lowest pending slot goes out next.
  assign cur_bit   = slots_r & (~slots_r + esf_slots_t'(1));
  assign rest      = slots_r & ~cur_bit;
  assign emit      = busy_r && out_ready;
  assign need_load = !busy_r || (emit && (rest == '0));
  assign q_pop     = need_load && !q_empty;

  always_comb begin
    if (cur_bit[SLOT_DATA]) begin
      cur_byte = data_r;
    end else if (cur_bit[SLOT_HDR_STX]) begin
      cur_byte = CODE_STX;
    end else if (cur_bit[SLOT_TRL_ETX]) begin
      cur_byte = CODE_ETX;
    end else if (cur_bit[SLOT_CSUM]) begin
      cur_byte = csum_r;
    end else begin
      cur_byte = CODE_ESC;
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    slots_nxt = slots_r;
    if (emit) begin
      slots_nxt = rest;
    end
    if (need_load) begin
      busy_nxt = !q_empty;
      if (!q_empty) begin
        slots_nxt = q_cmd.slots;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= q_cmd.data;
      csum_r <= q_cmd.csum;
    end
    if (emit) begin
      line_byte_r <= cur_byte;
      run_last_r  <= (rest == '0);
      frame_end_r <= cur_bit[SLOT_CSUM];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      slots_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      slots_r <= slots_nxt;
      if (out_ready) begin
        out_valid_r <= emit;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_line_byte = line_byte_r;
  assign out_run_last  = run_last_r;
  assign out_frame_end = frame_end_r;

endmodule
`default_nettype wire

FILE: rtl/core/escape_stuffed_frame_encoder_top.sv
// Top level of the escape-stuffed frame encoder.
`default_nettype none
// Builds framed serial commands from payload bytes: ESC STX before a frame's
// first byte, each byte copied (ESC sent twice), and ESC ETX plus an XOR
// checksum (payload bytes and ETX) after the byte marked last. The checksum
// byte carries out_frame_end; out_run_last marks the final line byte caused
// by one input request. The back end sends one line byte per cycle while
// out_stall is low; a request makes 1 to 7 line bytes (one for a mid-frame
// byte, two when that byte is ESC), and a four-entry queue lets the input
// take a new request every cycle while that queue has room. When all is
// idle, a taken request passes the queue entry, the back end's slot
// register and its output register before its first line byte appears.
module escape_stuffed_frame_encoder_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_line_byte,
  output logic            out_run_last,
  output logic            out_frame_end
);
  import esf_pkg::*;

  esf_cmd_t push_cmd, pop_cmd;
  logic     q_push, q_pop, q_full, q_empty;

  esf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  esf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  esf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_cmd         (pop_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_line_byte (out_line_byte),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end)
  );

endmodule
`default_nettype wire

FILE: sim/frame_checker.sv
`timescale 1ns / 100ps
// Line checker: predicts framed line bytes from accepted requests and compares the output.
module frame_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [7:0] out_line_byte,
  input  wire logic       out_run_last,
  input  wire logic       out_frame_end,
  output int              mismatch_count,
  output int              pending_bytes
);
  import esf_pkg::*;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_end;
  } line_entry_t;

  line_entry_t expected_line_q[$];
  line_entry_t want;
  logic        frame_open;
  logic [7:0]  frame_xor;

  // Expand one payload request into the line bytes it must produce.
  task automatic predict_line_bytes(input logic [7:0] payload, input logic closes);
    logic [7:0]  plan [0:NUM_SLOTS-1];
    int          n;
    int          csum_at;
    line_entry_t ent;
    n = 0;
    csum_at = -1;
    if (!frame_open) begin
      frame_xor = 8'h00;
      plan[n] = CODE_ESC;
      n = n + 1;
      plan[n] = CODE_STX;
      n = n + 1;
    end
    plan[n] = payload;
    n = n + 1;
    if (payload == CODE_ESC) begin
      plan[n] = CODE_ESC;
      n = n + 1;
    end
    frame_xor = frame_xor ^ payload;
    if (closes) begin
      plan[n] = CODE_ESC;
      n = n + 1;
      plan[n] = CODE_ETX;
      n = n + 1;
      plan[n] = frame_xor ^ CODE_ETX;
      csum_at = n;
      n = n + 1;
      frame_open = 1'b0;
      frame_xor = 8'h00;
    end else begin
      frame_open = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      ent.line_byte = plan[i];
      ent.run_last  = (i == n - 1);
      ent.frame_end = (i == csum_at);
      expected_line_q.push_back(ent);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_line_q.delete();
      frame_open = 1'b0;
      frame_xor = 8'h00;
      mismatch_count = 0;
      pending_bytes <= 0;
    end else begin
      if (in_valid && !in_stall) predict_line_bytes(in_data_byte, in_last_byte);
      if (out_valid && !out_stall) begin
        if (expected_line_q.size() == 0) begin
          $display("%0t: unexpected line byte: expected none, got %h", $time, out_line_byte);
          mismatch_count++;
        end else begin
          want = expected_line_q.pop_front();
          if (out_line_byte !== want.line_byte) begin
            $display("%0t: line_byte expected %h, got %h", $time, want.line_byte,
                     out_line_byte);
            mismatch_count++;
          end
          if (out_run_last !== want.run_last) begin
            $display("%0t: run_last expected %b, got %b (byte %h)", $time, want.run_last,
                     out_run_last, want.line_byte);
            mismatch_count++;
          end
          if (out_frame_end !== want.frame_end) begin
            $display("%0t: frame_end expected %b, got %b (byte %h)", $time, want.frame_end,
                     out_frame_end, want.line_byte);
            mismatch_count++;
          end
        end
      end
      pending_bytes <= expected_line_q.size();
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// Testbench top: drives payload requests and line-side stalls, and reports the verdict.
module testbench;
  import esf_pkg::*;

  localparam int RANDOM_REQUESTS = 250;
  localparam int DRAIN_CYCLES    = 20;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_line_byte;
  logic       out_run_last;
  logic       out_frame_end;

  int mismatch_count;
  int pending_bytes;
  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;
  int recv_hold = 0;

  escape_stuffed_frame_encoder_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_line_byte (out_line_byte),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end)
  );

  frame_checker line_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_line_byte  (out_line_byte),
    .out_run_last   (out_run_last),
    .out_frame_end  (out_frame_end),
    .mismatch_count (mismatch_count),
    .pending_bytes  (pending_bytes)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Line side: after each taken byte, stall for a random number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_hold <= 0;
    end else if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_stall <= (recv_hold > 1);
    end else if (out_valid && !out_stall) begin
      int n;
      if ($urandom_range(0, 40) == 0) recv_quiet = !recv_quiet;
      n = recv_quiet ? 0 : $urandom_range(0, 10);
      recv_hold <= n;
      out_stall <= (n > 0);
    end
  end

  // Keeps in_valid high across back-to-back requests; lowers it only for a gap.
  task automatic send_request(input logic [7:0] payload, input logic closes);
    int gap;
    if ($urandom_range(0, 30) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= payload;
    in_last_byte <= closes;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_line_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes != 0) @(posedge clk);
  endtask

  // Bias toward the framing codes so stuffing and checksum corners show up often.
  function automatic logic [7:0] pick_payload();
    case ($urandom_range(0, 9))
      0, 1:    return CODE_ESC;
      2:       return CODE_STX;
      3:       return CODE_ETX;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int sent;
    int len;
    int pause_at;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-byte frames, including a checksum that comes out zero
    send_request(8'h00, 1'b1);
    send_request(8'hFF, 1'b1);
    send_request(CODE_ESC, 1'b1);
    send_request(CODE_ETX, 1'b1);
    send_request(CODE_STX, 1'b1);
    // longer frame with back-to-back ESC and a pause mid-frame
    send_request(CODE_ESC, 1'b0);
    send_request(CODE_ESC, 1'b0);
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    wait_line_idle();
    send_request(8'h55, 1'b0);
    send_request(8'hAA, 1'b0);
    send_request(CODE_STX, 1'b0);
    send_request(CODE_ETX, 1'b0);
    send_request(CODE_ESC, 1'b1);
    send_request(8'h80, 1'b0);
    send_request(8'h01, 1'b1);
    send_request(8'h7F, 1'b0);
    send_request(CODE_ESC, 1'b0);
    send_request(8'hFE, 1'b1);
    wait_line_idle();

    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : -1;
      for (int i = 0; i < len; i++) begin
        send_request(pick_payload(), i == len - 1);
        if (i == pause_at) wait_line_idle();
      end
      sent += len;
    end

    wait_line_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/esf_pkg.sv
rtl/core/esf_front.sv
rtl/core/esf_queue.sv
rtl/core/esf_back.sv
rtl/core/escape_stuffed_frame_encoder_top.sv
sim/frame_checker.sv
sim/testbench.sv
